// ===== rtl/kdmm_pkg.sv =====
// kdmm_pkg: shared constants and the sine table generator for the kiwi-drive mixer
// no dependencies; imported by the core and the testbench
`timescale 1ns / 1ps

package kdmm_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned LIMIT_W     = 14;
    localparam int unsigned SINE_W      = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LIMIT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLTAGE_LIMIT = 8'd1;

    localparam logic [LIMIT_W-1:0] TURN_LIMIT_RESET    = 14'd6000;
    localparam logic [LIMIT_W-1:0] VOLTAGE_LIMIT_RESET = 14'd12000;

    // q2.14 mixing coefficients
    localparam logic signed [15:0] K_INV_SQRT3  = 16'sd9459;
    localparam logic signed [15:0] K_THIRD      = 16'sd5461;
    localparam logic signed [15:0] K_TWO_THIRDS = 16'sd10923;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [63:0] taylor_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // quarter-wave sine entry in unsigned q1.14, elaboration use only
    function automatic logic [SINE_W-1:0] sine_entry(input int bits, input int idx);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
        term = x;
        sum  = x;
        term = taylor_step(term, x) / 64'd6;   sum = sum - term;
        term = taylor_step(term, x) / 64'd20;  sum = sum + term;
        term = taylor_step(term, x) / 64'd42;  sum = sum - term;
        term = taylor_step(term, x) / 64'd72;  sum = sum + term;
        term = taylor_step(term, x) / 64'd110; sum = sum - term;
        term = taylor_step(term, x) / 64'd156; sum = sum + term;
        term = taylor_step(term, x) / 64'd210; sum = sum - term;
        term = taylor_step(term, x) / 64'd272; sum = sum + term;
        term = taylor_step(term, x) / 64'd342; sum = sum - term;
        term = taylor_step(term, x) / 64'd420; sum = sum + term;
        rnd  = (sum + 64'd32768) >> 16;
        return rnd[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/kdmm_ram.sv =====
// kdmm_ram: generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module kdmm_ram #(
    parameter int unsigned WIDTH = 15,
    parameter int unsigned DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/kiwi_drive_motor_mixer_core.sv =====
// kiwi_drive_motor_mixer_core: five stage field-oriented kiwi-drive mixer
// depends on kdmm_pkg and kdmm_ram (sine table storage)
// throughput one item per cycle while out_ready is high and the sine table load is done
// each stage holds its item under output back-pressure, bubbles close up
// reset: limits go to 6000 and 12000, pipeline empties; the sine table is then
// loaded one entry a cycle, 2^SINE_TABLE_BITS+1 entries (1025 by default),
// with in_ready low; configuration writes are taken throughout
`timescale 1ns / 1ps

module kiwi_drive_motor_mixer_core
    import kdmm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [14:0]       move_x,
    input  logic signed [14:0]       move_y,
    input  logic signed [14:0]       spin_term,
    input  logic [15:0]              heading,
    input  logic signed [14:0]       extra_rotation,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [14:0]       wheel_a,
    output logic signed [14:0]       wheel_b,
    output logic signed [14:0]       wheel_c,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [LIMIT_W-1:0]       cfg_data
);

    localparam int unsigned TBL_N = 1 << SINE_TABLE_BITS;
    localparam int unsigned DEPTH = TBL_N + 1;
    localparam int unsigned AW    = SINE_TABLE_BITS + 1;

    // configuration
    logic [LIMIT_W-1:0] turn_limit_reg;
    logic [LIMIT_W-1:0] voltage_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_limit_reg    <= TURN_LIMIT_RESET;
            voltage_limit_reg <= VOLTAGE_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TURN_LIMIT:    turn_limit_reg    <= cfg_data;
                CFG_VOLTAGE_LIMIT: voltage_limit_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // sine table load after reset
    logic [SINE_W-1:0] rom_const [DEPTH];
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_rom
        assign rom_const[gi] = sine_entry(SINE_TABLE_BITS, gi);
    end

    logic [AW-1:0] fill_idx_reg;
    logic [AW-1:0] fill_idx_next;
    logic          fill_busy_reg;
    logic          fill_busy_next;

    always_comb
    begin
        fill_idx_next  = fill_idx_reg;
        fill_busy_next = fill_busy_reg;
        if (fill_busy_reg)
        begin
            if (fill_idx_reg == AW'(TBL_N))
            begin
                fill_busy_next = 1'b0;
            end
            else
            begin
                fill_idx_next = fill_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg  <= '0;
            fill_busy_reg <= 1'b1;
        end
        else
        begin
            fill_idx_reg  <= fill_idx_next;
            fill_busy_reg <= fill_busy_next;
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5      = !v5_reg || out_ready;
    assign ld4      = !v4_reg || ld5;
    assign ld3      = !v3_reg || ld4;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign in_ready = ld1 && !fill_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid && in_ready;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // stage 1: table lookup addresses, registered read
    logic [1:0]                 quad_s;
    logic [1:0]                 quad_c;
    logic [SINE_TABLE_BITS-1:0] tbl_idx;
    logic [AW-1:0]              addr_fwd;
    logic [AW-1:0]              addr_rev;
    logic [AW-1:0]              raddr_s;
    logic [AW-1:0]              raddr_c;
    logic [SINE_W-1:0]          sin_raw;
    logic [SINE_W-1:0]          cos_raw;

    assign quad_s   = heading[15:14];
    assign quad_c   = quad_s + 2'd1;
    assign tbl_idx  = heading[13 -: SINE_TABLE_BITS];
    assign addr_fwd = {1'b0, tbl_idx};
    assign addr_rev = AW'(TBL_N) - {1'b0, tbl_idx};
    assign raddr_s  = quad_s[0] ? addr_rev : addr_fwd;
    assign raddr_c  = quad_c[0] ? addr_rev : addr_fwd;

    kdmm_ram #(
        .WIDTH (SINE_W),
        .DEPTH (DEPTH)
    ) u_sine_ram (
        .clk     (clk),
        .we      (fill_busy_reg),
        .waddr   (fill_idx_reg),
        .wdata   (rom_const[fill_idx_reg]),
        .re      (ld1),
        .raddr_a (raddr_s),
        .raddr_b (raddr_c),
        .rdata_a (sin_raw),
        .rdata_b (cos_raw)
    );

    logic signed [14:0] ax1_reg, ay1_reg, r1_reg, rot1_reg;
    logic               neg_s1_reg, neg_c1_reg;

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            ax1_reg    <= move_x;
            ay1_reg    <= move_y;
            r1_reg     <= spin_term;
            rot1_reg   <= extra_rotation;
            neg_s1_reg <= quad_s[1];
            neg_c1_reg <= quad_c[1];
        end
    end

    // stage 2: signed sine and cosine, coefficient products, rotation clamp
    logic signed [15:0] s1;
    logic signed [15:0] c1;
    logic signed [31:0] m_k3s, m_k1c, m_k3c, m_k1s, m_k2c, m_k2s;
    logic signed [15:0] rot_ext;
    logic signed [15:0] tlim_ext;
    logic signed [15:0] spin_wide;
    logic signed [14:0] spin2_next;

    always_comb
    begin
        s1 = neg_s1_reg ? -$signed({1'b0, sin_raw}) : $signed({1'b0, sin_raw});
        c1 = neg_c1_reg ? -$signed({1'b0, cos_raw}) : $signed({1'b0, cos_raw});
        m_k3s = K_INV_SQRT3 * s1;
        m_k1c = K_THIRD * c1;
        m_k3c = K_INV_SQRT3 * c1;
        m_k1s = K_THIRD * s1;
        m_k2c = K_TWO_THIRDS * c1;
        m_k2s = K_TWO_THIRDS * s1;
        rot_ext  = {rot1_reg[14], rot1_reg};
        tlim_ext = $signed({2'b00, turn_limit_reg});
        if (rot_ext > tlim_ext)
        begin
            spin_wide = tlim_ext;
        end
        else if (rot_ext < -tlim_ext)
        begin
            spin_wide = -tlim_ext;
        end
        else
        begin
            spin_wide = rot_ext;
        end
        spin2_next = spin_wide[14:0];
    end

    logic signed [14:0] ax2_reg, ay2_reg, r2_reg, spin2_reg;
    logic signed [29:0] p_k3s_reg, p_k1c_reg, p_k3c_reg, p_k1s_reg, p_k2c_reg, p_k2s_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            r2_reg    <= r1_reg;
            spin2_reg <= spin2_next;
            p_k3s_reg <= m_k3s[29:0];
            p_k1c_reg <= m_k1c[29:0];
            p_k3c_reg <= m_k3c[29:0];
            p_k1s_reg <= m_k1s[29:0];
            p_k2c_reg <= m_k2c[29:0];
            p_k2s_reg <= m_k2s[29:0];
        end
    end

    // stage 3: rounded matrix coefficients
    function automatic logic signed [15:0] round_coef(input logic signed [30:0] v);
        logic signed [30:0] t;
        t = v + 31'sd8192;
        return t[29:14];
    endfunction

    logic signed [30:0] sum_x [3];
    logic signed [30:0] sum_y [3];
    logic signed [15:0] cx_next [3];
    logic signed [15:0] cy_next [3];

    always_comb
    begin
        sum_x[0] = -p_k3s_reg - p_k1c_reg;
        sum_y[0] = p_k3c_reg - p_k1s_reg;
        sum_x[1] = p_k3s_reg - p_k1c_reg;
        sum_y[1] = -p_k3c_reg - p_k1s_reg;
        sum_x[2] = p_k2c_reg;
        sum_y[2] = p_k2s_reg;
        for (int j = 0; j < 3; j++)
        begin
            cx_next[j] = round_coef(sum_x[j]);
            cy_next[j] = round_coef(sum_y[j]);
        end
    end

    logic signed [14:0] ax3_reg, ay3_reg, r3_reg, spin3_reg;
    logic signed [15:0] cx3_reg [3];
    logic signed [15:0] cy3_reg [3];

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            r3_reg    <= r2_reg;
            spin3_reg <= spin2_reg;
            for (int j = 0; j < 3; j++)
            begin
                cx3_reg[j] <= cx_next[j];
                cy3_reg[j] <= cy_next[j];
            end
        end
    end

    // stage 4: wheel products
    logic signed [30:0] mx_next [3];
    logic signed [30:0] my_next [3];
    logic signed [30:0] mr_next;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            mx_next[j] = cx3_reg[j] * ax3_reg;
            my_next[j] = cy3_reg[j] * ay3_reg;
        end
        mr_next = K_THIRD * r3_reg;
    end

    logic signed [14:0] spin4_reg;
    logic signed [30:0] mx4_reg [3];
    logic signed [30:0] my4_reg [3];
    logic signed [30:0] mr4_reg;

    always_ff @(posedge clk)
    begin
        if (ld4)
        begin
            spin4_reg <= spin3_reg;
            mr4_reg   <= mr_next;
            for (int j = 0; j < 3; j++)
            begin
                mx4_reg[j] <= mx_next[j];
                my4_reg[j] <= my_next[j];
            end
        end
    end

    // stage 5: round, add rotation, saturate
    logic signed [32:0] total [3];
    logic signed [32:0] total_rnd [3];
    logic signed [19:0] with_spin [3];
    logic signed [19:0] vlim_ext;
    logic signed [19:0] sat [3];
    logic signed [14:0] w_next [3];
    logic signed [14:0] w5_reg [3];

    always_comb
    begin
        vlim_ext = $signed({6'd0, voltage_limit_reg});
        for (int j = 0; j < 3; j++)
        begin
            total[j]     = mx4_reg[j] + my4_reg[j] + mr4_reg;
            total_rnd[j] = total[j] + 33'sd8192;
            with_spin[j] = $signed(total_rnd[j][32:14]) + spin4_reg;
            if (with_spin[j] > vlim_ext)
            begin
                sat[j] = vlim_ext;
            end
            else if (with_spin[j] < -vlim_ext)
            begin
                sat[j] = -vlim_ext;
            end
            else
            begin
                sat[j] = with_spin[j];
            end
            w_next[j] = sat[j][14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld5)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w5_reg[j] <= w_next[j];
            end
        end
    end

    assign out_valid = v5_reg;
    assign wheel_a   = w5_reg[0];
    assign wheel_b   = w5_reg[1];
    assign wheel_c   = w5_reg[2];

endmodule

// ===== rtl/kdmm_checker.sv =====
// kdmm_checker: port-level assertions for the kiwi-drive mixer core
// no package needed; bound to kiwi_drive_motor_mixer_core below
`timescale 1ns / 1ps

module kdmm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic signed [14:0]     wheel_a,
    input logic signed [14:0]     wheel_b,
    input logic signed [14:0]     wheel_c
);

    localparam logic [2:0] PIPE_DEPTH = 3'd5;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       seen_reg;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            if (in_acc) seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wheel_a) && $stable(wheel_b)
            && $stable(wheel_c))
        else $error("stalled result changed");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result without an item in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= PIPE_DEPTH)
        else $error("more items in flight than stages");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg && inflight_reg < PIPE_DEPTH |-> in_ready)
        else $error("input stalled with a free stage");

endmodule

bind kiwi_drive_motor_mixer_core kdmm_checker u_kdmm_checker (.*);

// ===== tb/testbench.sv =====
// testbench: self-checking bench for kiwi_drive_motor_mixer_core
// needs kdmm_pkg and the core with its table storage; runs directed then random commands
`timescale 1ns / 1ps

module testbench;
    import kdmm_pkg::*;

    localparam int TBL_BITS = 10;
    localparam int SINE_N   = 1 << TBL_BITS;

    typedef struct packed {
        logic signed [14:0] move_x;
        logic signed [14:0] move_y;
        logic signed [14:0] spin_term;
        logic [15:0]        heading;
        logic signed [14:0] extra_rotation;
    } wheel_cmd_t;

    typedef struct packed {
        logic signed [14:0] wheel_a;
        logic signed [14:0] wheel_b;
        logic signed [14:0] wheel_c;
    } wheel_set_t;

    class wheel_scoreboard;
        int          sine_q14[0:SINE_N];
        int unsigned turn_lim;
        int unsigned volt_lim;
        wheel_set_t  expected_wheels[$];
        int          fail_count;

        function new();
            bit [63:0] x;
            bit [63:0] term;
            bit [63:0] sum;
            turn_lim   = TURN_LIMIT_RESET;
            volt_lim   = VOLTAGE_LIMIT_RESET;
            fail_count = 0;
            for (int i = 0; i <= SINE_N; i++)
            begin
                x    = (HALF_PI_Q30 * 64'(i)) >> TBL_BITS;
                term = x;
                sum  = x;
                for (int k = 1; k <= 10; k++)
                begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / 64'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                sine_q14[i] = int'((sum + 64'd32768) >> 16);
            end
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] data);
            if (idx == CFG_TURN_LIMIT)
                turn_lim = data;
            else if (idx == CFG_VOLTAGE_LIMIT)
                volt_lim = data;
        endfunction

        function longint sine_at(logic [15:0] angle);
            int     idx;
            longint v;
            idx = int'(angle[13:0]) >> (14 - TBL_BITS);
            v   = angle[14] ? sine_q14[SINE_N - idx] : sine_q14[idx];
            return angle[15] ? -v : v;
        endfunction

        function longint round_q14(longint v);
            return (v + 64'sd8192) >>> 14;
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function wheel_set_t mix_wheels(wheel_cmd_t cmd);
            longint             k1;
            longint             k2;
            longint             k3;
            longint             s;
            longint             c;
            longint             spin;
            longint             w;
            longint             cx[3];
            longint             cy[3];
            logic signed [14:0] wv[3];
            wheel_set_t         res;
            k1    = K_THIRD;
            k2    = K_TWO_THIRDS;
            k3    = K_INV_SQRT3;
            s     = sine_at(cmd.heading);
            c     = sine_at(cmd.heading + 16'd16384);
            cx[0] = round_q14(-k3 * s - k1 * c);
            cy[0] = round_q14(k3 * c - k1 * s);
            cx[1] = round_q14(k3 * s - k1 * c);
            cy[1] = round_q14(-k3 * c - k1 * s);
            cx[2] = round_q14(k2 * c);
            cy[2] = round_q14(k2 * s);
            spin  = clamp_sym(longint'(cmd.extra_rotation), longint'(turn_lim));
            for (int j = 0; j < 3; j++)
            begin
                w = round_q14(cx[j] * longint'(cmd.move_x) + cy[j] * longint'(cmd.move_y)
                              + k1 * longint'(cmd.spin_term));
                w = clamp_sym(w + spin, longint'(volt_lim));
                wv[j] = w[14:0];
            end
            res.wheel_a = wv[0];
            res.wheel_b = wv[1];
            res.wheel_c = wv[2];
            return res;
        endfunction

        function void note_command(wheel_cmd_t cmd);
            expected_wheels.push_back(mix_wheels(cmd));
        endfunction

        function void check_wheels(wheel_set_t got);
            wheel_set_t want;
            if (expected_wheels.size() == 0)
            begin
                $error("wheel item with no command waiting: %0d %0d %0d",
                       got.wheel_a, got.wheel_b, got.wheel_c);
                fail_count++;
                return;
            end
            want = expected_wheels.pop_front();
            if (got.wheel_a !== want.wheel_a)
            begin
                $error("wheel_a expected %0d actual %0d", want.wheel_a, got.wheel_a);
                fail_count++;
            end
            if (got.wheel_b !== want.wheel_b)
            begin
                $error("wheel_b expected %0d actual %0d", want.wheel_b, got.wheel_b);
                fail_count++;
            end
            if (got.wheel_c !== want.wheel_c)
            begin
                $error("wheel_c expected %0d actual %0d", want.wheel_c, got.wheel_c);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_wheels.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [14:0]       move_x;
    logic signed [14:0]       move_y;
    logic signed [14:0]       spin_term;
    logic [15:0]              heading;
    logic signed [14:0]       extra_rotation;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [14:0]       wheel_a;
    logic signed [14:0]       wheel_b;
    logic signed [14:0]       wheel_c;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [LIMIT_W-1:0]       cfg_data;

    wheel_scoreboard sb;
    int              tx_idle_pct;
    int              rx_stall_pct;

    kiwi_drive_motor_mixer_core #(
        .SINE_TABLE_BITS (TBL_BITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .move_x         (move_x),
        .move_y         (move_y),
        .spin_term      (spin_term),
        .heading        (heading),
        .extra_rotation (extra_rotation),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .wheel_a        (wheel_a),
        .wheel_b        (wheel_b),
        .wheel_c        (wheel_c),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_wheels('{wheel_a: wheel_a, wheel_b: wheel_b, wheel_c: wheel_c});
    end

    function automatic wheel_cmd_t make_cmd(int mx, int my, int sp, int hd, int rot);
        wheel_cmd_t cmd;
        cmd.move_x         = mx[14:0];
        cmd.move_y         = my[14:0];
        cmd.spin_term      = sp[14:0];
        cmd.heading        = hd[15:0];
        cmd.extra_rotation = rot[14:0];
        return cmd;
    endfunction

    function automatic logic signed [14:0] rand_field();
        int v;
        case ($urandom_range(9))
            0: v = $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: v = -12000;
                    1: v = 12000;
                    2: v = 0;
                    3: v = -16384;
                    default: v = 16383;
                endcase
            end
            default: v = int'($urandom_range(24000)) - 12000;
        endcase
        return v[14:0];
    endfunction

    function automatic wheel_cmd_t rand_cmd();
        wheel_cmd_t cmd;
        int         hd;
        cmd.move_x    = rand_field();
        cmd.move_y    = rand_field();
        cmd.spin_term = rand_field();
        if ($urandom_range(7) == 0)
            hd = int'($urandom_range(3)) * 16384 + int'($urandom_range(31)) - 16;
        else
            hd = $urandom;
        cmd.heading        = hd[15:0];
        cmd.extra_rotation = rand_field();
        return cmd;
    endfunction

    task automatic send_command(wheel_cmd_t cmd);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        move_x         = cmd.move_x;
        move_y         = cmd.move_y;
        spin_term      = cmd.spin_term;
        heading        = cmd.heading;
        extra_rotation = cmd.extra_rotation;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(cmd);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic switch_limits(int tl, int vl);
        wait_drained();
        write_register(CFG_TURN_LIMIT, tl[LIMIT_W-1:0]);
        write_register(CFG_VOLTAGE_LIMIT, vl[LIMIT_W-1:0]);
        write_register(CFG_INDEX_W'($urandom_range(255, 2)), LIMIT_W'($urandom));
    endtask

    task automatic run_phase(int n, int tx_pct, int rx_pct, int pause_at);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_drained();
            send_command(rand_cmd());
        end
    endtask

    initial
    begin
        sb             = new();
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        move_x         = '0;
        move_y         = '0;
        spin_term      = '0;
        heading        = '0;
        extra_rotation = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // directed commands under the reset limits
        send_command(make_cmd(0, 0, 0, 0, 0));
        send_command(make_cmd(12000, 0, 0, 0, 0));
        send_command(make_cmd(-12000, 0, 0, 16384, 0));
        send_command(make_cmd(0, 12000, 0, 32768, 0));
        send_command(make_cmd(0, -12000, 0, 49152, 0));
        send_command(make_cmd(0, 0, 12000, 65535, 0));
        send_command(make_cmd(0, 0, -12000, 8192, 0));
        send_command(make_cmd(12000, 12000, 12000, 0, 12000));
        send_command(make_cmd(-12000, -12000, -12000, 24576, -12000));
        send_command(make_cmd(16383, 16383, 16383, 40960, 16383));
        send_command(make_cmd(-16384, -16384, -16384, 57344, -16384));
        send_command(make_cmd(0, 0, 0, 0, 6000));
        send_command(make_cmd(0, 0, 0, 0, 6001));
        send_command(make_cmd(0, 0, 0, 0, -6001));
        send_command(make_cmd(3000, -4000, 1000, 15, -300));
        send_command(make_cmd(3000, -4000, 1000, 16383, 2500));
        send_command(make_cmd(3000, -4000, 1000, 16399, 0));
        send_command(make_cmd(-5000, 7000, -2000, 65520, 100));
        send_command(make_cmd(1, 1, 1, 1, 1));
        send_command(make_cmd(-1, -1, -1, 43690, -1));

        switch_limits(12000, 12000);
        run_phase(300, 0, 0, -1);
        switch_limits(0, 5000);
        run_phase(250, 57, 0, 120);
        switch_limits(16383, 16383);
        run_phase(250, 0, 57, -1);
        switch_limits(3000, 0);
        run_phase(150, 21, 21, -1);
        switch_limits($urandom_range(12000), $urandom_range(12000));
        run_phase(200, 0, 0, -1);

        @(negedge clk);
        in_valid = 1'b0;
        for (int w = 0; w < 20000 && sb.pending() != 0; w++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d wheel items never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/kdmm_pkg.sv
rtl/kdmm_ram.sv
rtl/kiwi_drive_motor_mixer_core.sv
rtl/kdmm_checker.sv
tb/testbench.sv
